@@ hdl/sdas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdas_pkg;

    localparam int CHAR_W = 8;
    localparam int BCD_W  = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Shift-and-add-3 correction: a digit of 5 or more gets 3 added before the shift
    localparam logic [BCD_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [BCD_W-1:0] DABBLE_ADJ   = 4'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } sdas_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic neg;
        logic digit_last;
    } sdas_status_t;

endpackage

`default_nettype wire

@@ hdl/sdas_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdas_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output sdas_pkg::sdas_cmd_t   cmd,
    input  sdas_pkg::sdas_status_t status
);
    import sdas_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_last)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.digit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/sdas_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdas_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdas_pkg::sdas_cmd_t             cmd,
    output sdas_pkg::sdas_status_t          status,
    input  logic [VALUE_WIDTH-1:0]          value,
    output logic                            strobe,
    output logic [sdas_pkg::CHAR_W-1:0]     char_code,
    output logic                            last
);
    import sdas_pkg::*;

    // Decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1)
    localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int IdxW      = $clog2(NumDigits);
    localparam int DcntW     = $clog2(NumDigits + 1);
    localparam int CntW      = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [BCD_W-1:0]       digits_reg [NumDigits];
    logic [CntW-1:0]        bit_cnt_reg;
    logic [DcntW-1:0]       dcnt_reg;
    logic [IdxW-1:0]        idx_reg;
    logic [CHAR_W-1:0]      char_code_reg;
    logic                   last_reg;
    logic                   strobe_reg;

    logic [BCD_W-1:0]       adj        [NumDigits];
    logic [BCD_W-1:0]       shifted    [NumDigits];
    logic [DcntW-1:0]       dcnt_next;

    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            adj[i] = (digits_reg[i] >= DABBLE_LIMIT) ? digits_reg[i] + DABBLE_ADJ
                                                     : digits_reg[i];
        end
        shifted[0] = {adj[0][BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
        for (int i = 1; i < NumDigits; i++)
        begin
            shifted[i] = {adj[i][BCD_W-2:0], adj[i-1][BCD_W-1]};
        end
        // Only the digit just above the current top can turn nonzero in one shift
        dcnt_next = dcnt_reg;
        if (dcnt_reg < DcntW'(NumDigits))
        begin
            if (shifted[dcnt_reg[IdxW-1:0]] != '0)
            begin
                dcnt_next = dcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg     <= value[VALUE_WIDTH-1];
            mag_reg     <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            bit_cnt_reg <= CntW'(VALUE_WIDTH);
            dcnt_reg    <= DcntW'(1);
            idx_reg     <= '0;
            for (int i = 0; i < NumDigits; i++)
            begin
                digits_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            mag_reg     <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            dcnt_reg    <= dcnt_next;
            idx_reg     <= IdxW'(dcnt_next - 1'b1);
            for (int i = 0; i < NumDigits; i++)
            begin
                digits_reg[i] <= shifted[i];
            end
        end
        else if (cmd.emit_digit)
        begin
            idx_reg <= idx_reg - 1'b1;
        end

        if (cmd.emit_sign)
        begin
            char_code_reg <= ASCII_MINUS;
            last_reg      <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_code_reg <= ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, digits_reg[idx_reg]};
            last_reg      <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign | cmd.emit_digit;
        end
    end

    assign status.conv_last  = (bit_cnt_reg == CntW'(1));
    assign status.neg        = neg_reg;
    assign status.digit_last = (idx_reg == '0);

    assign strobe    = strobe_reg;
    assign char_code = char_code_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

@@ hdl/signed_decimal_ascii_serializer.sv @@
// Channel    Ports                         Transaction
// ---------  ----------------------------  -----------------------------------------
// input      start, busy, value            accepted at a rising edge with start & !busy
// result     strobe, char_code, last       each character shown for one cycle, strobe high
//
// Sequence: a transaction first runs the binary-to-BCD shift-and-add-3 loop,
// one input bit per cycle, then emits a '-' for a negative value, then the D
// digits (D being the digit count), most significant first, one character
// per cycle; last is set on the final character.
// Reset clears the controller and the result strobe; no other register is reset.
// The receiver cannot stall: each character is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_ascii_serializer #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [VALUE_WIDTH-1:0]       value,
    output logic                         strobe,
    output logic [sdas_pkg::CHAR_W-1:0]  char_code,
    output logic                         last
);
    import sdas_pkg::*;

    sdas_cmd_t    cmd;
    sdas_status_t status;

    sdas_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    sdas_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

endmodule

`default_nettype wire

@@ tb/decimal_text_checker.sv @@
`timescale 1ns / 1ps

module decimal_text_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [VALUE_WIDTH-1:0]       value,
    input  logic                         strobe,
    input  logic [sdas_pkg::CHAR_W-1:0]  char_code,
    input  logic                         last,
    output int                           failures,
    output int                           pending
);

    import sdas_pkg::*;

    localparam int DIGIT_BASE = 10;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];
    text_char_t got_char;
    text_char_t want_char;
    int         fail_count = 0;
    int         pending_count = 0;

    assign failures = fail_count;
    assign pending  = pending_count;

    // Append the decimal text of one number, sign first, most significant digit next
    function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [CHAR_W-1:0]      rev [0:23];
        logic                   neg;
        int                     n;
        text_char_t             c;
        neg = v[VALUE_WIDTH-1];
        // unsigned negation keeps the most negative value exact
        mag = neg ? (~v + 1'b1) : v;
        n = 0;
        do
        begin
            rev[n] = ASCII_ZERO + CHAR_W'(mag % DIGIT_BASE);
            n++;
            mag = mag / DIGIT_BASE;
        end
        while (mag != 0);
        if (neg)
        begin
            rev[n] = ASCII_MINUS;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            c.code = rev[k];
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check the character leaving this cycle before queuing new text
            if (strobe)
            begin
                got_char.code = char_code;
                got_char.last = last;
                if (expected_text.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected character: code=%h last=%b",
                                 $realtime, char_code, last);
                end
                else
                begin
                    want_char = expected_text.pop_front();
                    if (got_char.code !== want_char.code || got_char.last !== want_char.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: character mismatch: expected code=%h last=%b, got code=%h last=%b",
                                     $realtime, want_char.code, want_char.last,
                                     got_char.code, got_char.last);
                    end
                end
            end
            if (start && !busy)
                queue_decimal_text(value);
            pending_count = expected_text.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int VW          = 32;
    localparam int RANDOM_ITEMS = 208;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CORNER_COUNT = 22;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [VW-1:0]                value;
    logic                         strobe;
    logic [sdas_pkg::CHAR_W-1:0]  char_code;
    logic                         last;
    int                           failures;
    int                           pending;
    int                           cycles = 0;

    int corner_values [CORNER_COUNT] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        2147483647, 32'h8000_0000, -2147483647, 1000000000, 999999999,
        -999999999, 1234567890, -1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
        7, -5
    };

    signed_decimal_ascii_serializer #(
        .VALUE_WIDTH (VW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

    decimal_text_checker #(
        .VALUE_WIDTH (VW)
    ) text_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one number at a falling edge, hold it until accepted, return at a falling edge
    task automatic send_number(input logic [VW-1:0] v);
        start <= 1'b1;
        value <= v;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    // Sometimes drop start for a random burst, at times first waiting for the serializer to drain
    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(1, 9);
            start <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                while (busy)
                    @(negedge clk);
            repeat (n)
            begin
                value <= $urandom;
                @(negedge clk);
            end
        end
    endtask

    // Mostly numbers of a chosen digit count, some raw bit patterns
    function automatic logic [VW-1:0] pick_number();
        longint lo;
        longint hi;
        longint mag;
        int     digits;
        logic   neg;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        digits = $urandom_range(1, 10);
        neg = 1'($urandom_range(0, 1));
        lo = 1;
        repeat (digits - 1)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1)
            lo = 0;
        if (hi > 64'sd2147483647)
            hi = neg ? 64'sd2147483648 : 64'sd2147483647;
        case ($urandom_range(0, 5))
            0:       mag = lo;
            1:       mag = hi;
            default: mag = lo + (longint'($urandom) % (hi - lo + 1));
        endcase
        return neg ? VW'(-mag) : VW'(mag);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            send_number(VW'(corner_values[i]));
            sender_gap();
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_number(pick_number());
            if (i < RANDOM_ITEMS - CALM_ITEMS)
                sender_gap();
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sdas_pkg.sv
hdl/sdas_ctrl.sv
hdl/sdas_dp.sv
hdl/signed_decimal_ascii_serializer.sv
tb/decimal_text_checker.sv
tb/testbench.sv
